>>> hw/rtl/krst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package krst_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int OUT_SLOTS = 6;

	localparam logic [1:0] CMD_KEY      = 2'd0;
	localparam logic [1:0] CMD_LED      = 2'd1;
	localparam logic [1:0] CMD_CAPS_REL = 2'd2;

	localparam logic REG_UNLOCKED_CAPS = 1'b0;
	localparam logic REG_CAPS_USAGE    = 1'b1;

	localparam logic [6:0] RAW_CAPS       = 7'h39;
	localparam int         RAW_RELEASE    = 7;
	localparam int         LED_CAPS       = 1;
	localparam logic [4:0] MOD_PREFIX     = 5'h1C;
	localparam logic [7:0] CAPS_USAGE_RST = 8'd57;

	typedef enum logic [1:0] {
		OUT_OK      = 2'd0,
		OUT_ABSENT  = 2'd1,
		OUT_PRESENT = 2'd2,
		OUT_FULL    = 2'd3
	} outcome_t;

	typedef logic [KEY_SLOTS-1:0][7:0] slots_t;

	typedef struct packed {
		logic [7:0] usage;
		logic       rel;
		logic [7:0] mask;
		slots_t     slots;
	} key_req_t;

	typedef struct packed {
		logic [7:0] mask;
		slots_t     slots;
		outcome_t   outcome;
	} key_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/krst_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface krst_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] adb_byte;
	logic [7:0] usage_code;
	logic [7:0] led_bits;

	modport source (output valid, cmd, adb_byte, usage_code, led_bits, input ready);
	modport sink (input valid, cmd, adb_byte, usage_code, led_bits, output ready);
endinterface

interface krst_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] modifier_bits;
	logic [7:0] slot0;
	logic [7:0] slot1;
	logic [7:0] slot2;
	logic [7:0] slot3;
	logic [7:0] slot4;
	logic [7:0] slot5;
	logic       caps_was_released;
	logic [1:0] outcome;

	modport source (output valid, modifier_bits, slot0, slot1, slot2, slot3, slot4, slot5,
		caps_was_released, outcome, input ready);
	modport sink (input valid, modifier_bits, slot0, slot1, slot2, slot3, slot4, slot5,
		caps_was_released, outcome, output ready);
endinterface

interface krst_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/krst_key_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module krst_key_unit (
	input  krst_pkg::key_req_t req,
	output krst_pkg::key_res_t res
);
	import krst_pkg::*;

	logic [KEY_SLOTS-1:0] match;
	logic [KEY_SLOTS-1:0] empty;
	logic [KEY_SLOTS-1:0] hit_oh;
	logic [KEY_SLOTS-1:0] fill_oh;
	logic                 hit_seen;
	logic                 fill_seen;
	logic                 is_mod;
	logic [7:0]           mod_bit;

	always_comb begin
		hit_seen  = 1'b0;
		fill_seen = 1'b0;
		for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
			match[i]   = (req.slots[i] == req.usage);
			empty[i]   = (req.slots[i] == 8'd0);
			hit_oh[i]  = match[i] && !hit_seen;
			fill_oh[i] = empty[i] && !fill_seen;
			hit_seen   = hit_seen || match[i];
			fill_seen  = fill_seen || empty[i];
		end
	end

	assign is_mod  = (req.usage[7:3] == MOD_PREFIX);
	assign mod_bit = 8'd1 << req.usage[2:0];

	always_comb begin
		res.mask    = req.mask;
		res.slots   = req.slots;
		res.outcome = OUT_OK;
		if (req.usage == 8'd0) begin
			res.outcome = OUT_OK;
		end else if (is_mod) begin
			if (req.rel) begin
				res.mask = req.mask & ~mod_bit;
			end else begin
				res.mask = req.mask | mod_bit;
			end
		end else if (req.rel) begin
			if (!hit_seen) begin
				res.outcome = OUT_ABSENT;
			end else begin
				for (int i = 0; i < KEY_SLOTS; i++) begin
					if (hit_oh[i]) begin
						res.slots[i] = 8'd0;
					end
				end
			end
		end else if (hit_seen) begin
			res.outcome = OUT_PRESENT;
		end else if (!fill_seen) begin
			res.outcome = OUT_FULL;
		end else begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (fill_oh[i]) begin
					res.slots[i] = req.usage;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/keyboard_report_state_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Keeps a boot keyboard report (modifier mask and six key slots) and applies one
// command word per cycle unless the result stalls: key events, caps LED updates
// and caps release requests. Each accepted word yields one result word holding the
// report after the step, the caps release flag and an outcome code. A word passes
// the input register and then the result register, with all slot compares and the
// priority fill between them. A stalled result holds the input register, so the
// input side stalls one word later. Configuration writes are always accepted and
// are registered before they apply to later words.

module keyboard_report_state_tracker_unit (
	input  wire       clk,
	input  wire       arst_n,
	krst_in_if.sink   req,
	krst_out_if.source rsp,
	krst_cfg_if.sink  cfg
);
	import krst_pkg::*;

	logic       unlocked_q;
	logic [7:0] caps_usage_q;

	logic [7:0] mask_q;
	slots_t     slots_q;
	logic       caps_pending_q;
	logic       caps_active_q;
	logic       last_led_q;

	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] adb_byte_s1;
	logic [7:0] usage_s1;
	logic [7:0] leds_s1;

	logic     rsp_valid_q;
	logic     released_q;
	outcome_t outcome_q;

	logic     in_ready;
	logic     advance;
	logic     step;

	key_req_t key_req;
	key_res_t key_res;
	logic     pending_n;
	logic     active_n;
	logic     last_led_n;
	logic     released_n;

	assign advance  = !rsp_valid_q || rsp.ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;
	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	// command decode around the key unit
	always_comb begin
		key_req.usage = 8'd0;
		key_req.rel   = 1'b0;
		key_req.mask  = mask_q;
		key_req.slots = slots_q;
		pending_n     = caps_pending_q;
		active_n      = caps_active_q;
		last_led_n    = last_led_q;
		released_n    = 1'b0;
		case (cmd_s1)
			CMD_KEY: begin
				if (!unlocked_q && adb_byte_s1[6:0] == RAW_CAPS) begin
					if (caps_active_q != !adb_byte_s1[RAW_RELEASE]) begin
						active_n      = !adb_byte_s1[RAW_RELEASE];
						pending_n     = 1'b1;
						key_req.usage = caps_usage_q;
					end
				end else begin
					key_req.usage = usage_s1;
					key_req.rel   = adb_byte_s1[RAW_RELEASE];
				end
			end
			CMD_LED: begin
				if (!unlocked_q && leds_s1[LED_CAPS] != last_led_q) begin
					last_led_n = leds_s1[LED_CAPS];
					active_n   = leds_s1[LED_CAPS];
				end
			end
			CMD_CAPS_REL: begin
				if (!unlocked_q && caps_pending_q) begin
					pending_n     = 1'b0;
					key_req.usage = caps_usage_q;
					key_req.rel   = 1'b1;
					released_n    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	krst_key_unit u_key (
		.req (key_req),
		.res (key_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unlocked_q   <= 1'b0;
			caps_usage_q <= CAPS_USAGE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_UNLOCKED_CAPS: unlocked_q   <= cfg.data[0];
				REG_CAPS_USAGE:    caps_usage_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && req.valid) begin
			cmd_s1      <= req.cmd;
			adb_byte_s1 <= req.adb_byte;
			usage_s1    <= req.usage_code;
			leds_s1     <= req.led_bits;
		end
	end

	// report state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q         <= 8'd0;
			slots_q        <= '0;
			caps_pending_q <= 1'b0;
			caps_active_q  <= 1'b0;
			last_led_q     <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
			if (step) begin
				mask_q         <= key_res.mask;
				slots_q        <= key_res.slots;
				caps_pending_q <= pending_n;
				caps_active_q  <= active_n;
				last_led_q     <= last_led_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			released_q <= released_n;
			outcome_q  <= key_res.outcome;
		end
	end

	logic [OUT_SLOTS-1:0][7:0] out_slots;

	for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_out_slot
		if (j < KEY_SLOTS) begin : g_used
			assign out_slots[j] = slots_q[j];
		end else begin : g_unused
			assign out_slots[j] = 8'd0;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.modifier_bits     = mask_q;
	assign rsp.slot0             = out_slots[0];
	assign rsp.slot1             = out_slots[1];
	assign rsp.slot2             = out_slots[2];
	assign rsp.slot3             = out_slots[3];
	assign rsp.slot4             = out_slots[4];
	assign rsp.slot5             = out_slots[5];
	assign rsp.caps_was_released = released_q;
	assign rsp.outcome           = outcome_q;

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(slots_q) && $stable(mask_q) && $stable(caps_pending_q))
		else $error("report state changed without a word");

	a_led_no_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		step && cmd_s1 == CMD_LED |=> outcome_q == OUT_OK && !released_q && $stable(slots_q))
		else $error("led update touched the key list");

	a_caps_release: assert property (@(posedge clk) disable iff (!arst_n)
		step && cmd_s1 == CMD_CAPS_REL && !unlocked_q && caps_pending_q
		|=> !caps_pending_q && released_q)
		else $error("caps release request missed a pending press");

	a_release_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && released_q |-> outcome_q == OUT_OK || outcome_q == OUT_ABSENT)
		else $error("caps release reported a press outcome");

	a_unlocked_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		unlocked_q |=> !$rose(caps_pending_q))
		else $error("caps press emulated in unlocked mode");

endmodule

`default_nettype wire
